FILE: rtl/core/tlwd_pkg.sv
// package for the two-level work deque: state codes, result codes,
// register indexes and default sizes; no dependencies
`timescale 1ns / 1ps
package tlwd_pkg;
  localparam int unsigned WORKERS_DEF      = 4;
  localparam int unsigned LOCAL_DEPTH_DEF  = 256;
  localparam int unsigned GLOBAL_DEPTH_DEF = 512;

  localparam logic [1:0] ST_DELIVERED = 2'd0;
  localparam logic [1:0] ST_PUSHED    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [1:0] ST_NO_WORK   = 2'd3;

  localparam logic [1:0] CFG_WAITER_OFFER_MIN = 2'd0;
  localparam logic [1:0] CFG_GLOBAL_LOW_MARK  = 2'd1;
  localparam logic [1:0] CFG_LOCAL_HIGH_MARK  = 2'd2;
  localparam logic [1:0] CFG_GRAB_MAX         = 2'd3;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_TAKE = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_PUSH, S_OFFER_EVAL, S_OFF_RD, S_OFF_WR, S_REFILL_CHK,
    S_REF_TEST, S_REF_RD, S_REF_WR, S_POP_CHK, S_POP_RD, S_POP_WR, S_RESP
  } seq_state_e;
endpackage

FILE: rtl/core/two_level_work_deque.sv
// two-level work deque top level: per-worker ring deques plus a global ring
// deque, one memory each, moved one item at a time by a sequencer; uses tlwd_pkg
`timescale 1ns / 1ps
// sequence: a plain push writes the local deque and then answers; a take offers,
//   refills and pops in turn; a push into a full deque runs the offer check and retries;
//   an offer moves each item in a read and a write state, a refill in test, read, write
// throughput: one operation at a time, busy_o high until the done cycle ends
// reset: pointers, fills and registers return to defaults at once, no sweep;
//   the receiver cannot stall, done_o is a single-cycle strobe
module two_level_work_deque #(
  parameter int unsigned WORKERS      = tlwd_pkg::WORKERS_DEF,
  parameter int unsigned LOCAL_DEPTH  = tlwd_pkg::LOCAL_DEPTH_DEF,
  parameter int unsigned GLOBAL_DEPTH = tlwd_pkg::GLOBAL_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        func_i,
  input  logic [1:0]  worker_i,
  input  logic [63:0] item_i,
  input  logic [2:0]  waiting_workers_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [9:0]  cfg_data_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [63:0] item_out_o,
  output logic [8:0]  local_count_o,
  output logic [9:0]  global_count_o
);
  import tlwd_pkg::*;

  localparam int unsigned WW  = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int unsigned LW  = $clog2(LOCAL_DEPTH);
  localparam int unsigned LFW = $clog2(LOCAL_DEPTH + 1);
  localparam int unsigned GW  = $clog2(GLOBAL_DEPTH);
  localparam int unsigned GFW = $clog2(GLOBAL_DEPTH + 1);
  localparam int unsigned CNW = (LFW > 4) ? LFW : 4;

  seq_state_e state_q, state_d;

  logic [8:0] wom_q;
  logic [9:0] glm_q;
  logic [8:0] lhm_q;
  logic [3:0] gm_q;

  logic          func_q;
  logic [WW-1:0] w_q;
  logic [63:0]   item_q;
  logic [2:0]    wait_q;
  logic          retry_q, retry_d;
  logic [CNW-1:0] cnt_q, cnt_d;
  logic [1:0]    status_q, status_d;
  logic [63:0]   out_q;
  logic          out_load;

  logic [LW-1:0]  l_head_q [WORKERS];
  logic [LW-1:0]  l_top_q  [WORKERS];
  logic [LFW-1:0] l_fill_q [WORKERS];
  logic [LW-1:0]  l_head_d [WORKERS];
  logic [LW-1:0]  l_top_d  [WORKERS];
  logic [LFW-1:0] l_fill_d [WORKERS];
  logic [GW-1:0]  g_head_q, g_head_d, g_top_q, g_top_d;
  logic [GFW-1:0] g_fill_q, g_fill_d;

  logic [63:0] l_mem [WORKERS][LOCAL_DEPTH];
  logic [63:0] g_mem [GLOBAL_DEPTH];
  logic        l_we, g_we;
  logic [LW-1:0] l_waddr, l_raddr;
  logic [GW-1:0] g_waddr, g_raddr;
  logic [63:0] l_wdata, g_wdata, l_rdata_q, g_rdata_q;

  // worker index wraps modulo the worker count
  logic [WW-1:0] w_in;
  always_comb begin
    logic [2:0] t;
    t = {1'b0, worker_i};
    for (int k = 0; k < 4; k++) begin
      if (t >= 3'(WORKERS)) t = t - 3'(WORKERS);
    end
    w_in = WW'(t);
  end

  logic [LW-1:0]  cur_head, cur_top;
  logic [LFW-1:0] cur_fill;
  assign cur_head = l_head_q[w_q];
  assign cur_top  = l_top_q[w_q];
  assign cur_fill = l_fill_q[w_q];

  function automatic logic [LW-1:0] l_up(input logic [LW-1:0] p);
    return (p == LW'(LOCAL_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction
  function automatic logic [LW-1:0] l_dn(input logic [LW-1:0] p);
    return (p == '0) ? LW'(LOCAL_DEPTH - 1) : p - 1'b1;
  endfunction
  function automatic logic [GW-1:0] g_up(input logic [GW-1:0] p);
    return (p == GW'(GLOBAL_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction
  function automatic logic [GW-1:0] g_dn(input logic [GW-1:0] p);
    return (p == '0) ? GW'(GLOBAL_DEPTH - 1) : p - 1'b1;
  endfunction

  logic l_full, l_empty, g_empty, offer_go;
  logic [LFW-1:0] half;
  logic [GFW-1:0] room;
  logic [CNW-1:0] n_off;
  assign l_full  = (cur_fill >= LFW'(LOCAL_DEPTH));
  assign l_empty = (cur_fill == '0);
  assign g_empty = (g_fill_q == '0);
  assign half    = cur_fill >> 1;
  assign room    = GFW'(GLOBAL_DEPTH) - g_fill_q;
  assign offer_go = ((wait_q != 3'd0) && (32'(cur_fill) > 32'(wom_q))) ||
                    ((32'(g_fill_q) < 32'(glm_q)) && (32'(cur_fill) > 32'(lhm_q)));
  assign n_off = (32'(half) > 32'(room)) ? CNW'(room) : CNW'(half);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:       if (start_i) state_d = (func_i == FUNC_PUSH) ? S_PUSH : S_OFFER_EVAL;
      S_PUSH:       state_d = (!l_full || retry_q) ? S_RESP : S_OFFER_EVAL;
      S_OFFER_EVAL: begin
        if (offer_go && n_off != '0) state_d = S_OFF_RD;
        else state_d = (func_q == FUNC_PUSH) ? S_PUSH : S_REFILL_CHK;
      end
      S_OFF_RD:     state_d = S_OFF_WR;
      S_OFF_WR: begin
        if (cnt_q != CNW'(1)) state_d = S_OFF_RD;
        else state_d = (func_q == FUNC_PUSH) ? S_PUSH : S_REFILL_CHK;
      end
      S_REFILL_CHK: state_d = l_empty ? S_REF_TEST : S_POP_CHK;
      S_REF_TEST:   state_d = (cnt_q == '0 || g_empty || l_full) ? S_POP_CHK : S_REF_RD;
      S_REF_RD:     state_d = S_REF_WR;
      S_REF_WR:     state_d = S_REF_TEST;
      S_POP_CHK:    state_d = l_empty ? S_RESP : S_POP_RD;
      S_POP_RD:     state_d = S_POP_WR;
      S_POP_WR:     state_d = S_RESP;
      S_RESP:       state_d = S_IDLE;
      default:      state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    l_head_d = l_head_q;
    l_top_d  = l_top_q;
    l_fill_d = l_fill_q;
    g_head_d = g_head_q;
    g_top_d  = g_top_q;
    g_fill_d = g_fill_q;
    retry_d  = retry_q;
    cnt_d    = cnt_q;
    status_d = status_q;
    out_load = 1'b0;
    l_we = 1'b0; l_waddr = cur_top; l_wdata = item_q; l_raddr = cur_top;
    g_we = 1'b0; g_waddr = g_top_q; g_wdata = l_rdata_q; g_raddr = g_top_q;
    case (state_q)
      S_IDLE: begin
        retry_d  = 1'b0;
        out_load = start_i;
      end
      S_PUSH: begin
        if (!l_full) begin
          l_we = 1'b1;
          if (l_empty) l_head_d[w_q] = cur_top;
          else begin
            l_top_d[w_q] = l_up(cur_top);
            l_waddr = l_up(cur_top);
          end
          l_fill_d[w_q] = cur_fill + 1'b1;
          status_d = ST_PUSHED;
        end else if (retry_q) begin
          status_d = ST_OVERFLOW;
        end
        retry_d = 1'b1;
      end
      S_OFFER_EVAL: cnt_d = n_off;
      S_OFF_RD:     l_raddr = cur_head;
      S_OFF_WR: begin
        // bottom of local goes onto global top
        l_head_d[w_q] = l_up(cur_head);
        l_fill_d[w_q] = cur_fill - 1'b1;
        g_we = 1'b1;
        if (g_empty) g_head_d = g_top_q;
        else begin
          g_top_d = g_up(g_top_q);
          g_waddr = g_up(g_top_q);
        end
        g_fill_d = g_fill_q + 1'b1;
        cnt_d = cnt_q - 1'b1;
      end
      S_REFILL_CHK: cnt_d = CNW'(gm_q);
      S_REF_WR: begin
        g_top_d  = g_dn(g_top_q);
        g_fill_d = g_fill_q - 1'b1;
        l_we = 1'b1;
        l_wdata = g_rdata_q;
        if (l_empty) l_head_d[w_q] = cur_top;
        else begin
          l_top_d[w_q] = l_up(cur_top);
          l_waddr = l_up(cur_top);
        end
        l_fill_d[w_q] = cur_fill + 1'b1;
        cnt_d = cnt_q - 1'b1;
      end
      S_POP_CHK: if (l_empty) status_d = ST_NO_WORK;
      S_POP_WR: begin
        l_top_d[w_q]  = l_dn(cur_top);
        l_fill_d[w_q] = cur_fill - 1'b1;
        status_d = ST_DELIVERED;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (l_we) l_mem[w_q][l_waddr] <= l_wdata;
    l_rdata_q <= l_mem[w_q][l_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (g_we) g_mem[g_waddr] <= g_wdata;
    g_rdata_q <= g_mem[g_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      func_q <= func_i;
      w_q    <= w_in;
      item_q <= item_i;
      wait_q <= waiting_workers_i;
    end
    if (out_load) out_q <= '0;
    else if (state_q == S_POP_WR) out_q <= l_rdata_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      retry_q  <= 1'b0;
      cnt_q    <= '0;
      status_q <= ST_NO_WORK;
      for (int k = 0; k < WORKERS; k++) begin
        l_head_q[k] <= '0;
        l_top_q[k]  <= '0;
        l_fill_q[k] <= '0;
      end
      g_head_q <= '0;
      g_top_q  <= '0;
      g_fill_q <= '0;
      wom_q <= 9'd2;
      glm_q <= 10'd128;
      lhm_q <= 9'd128;
      gm_q  <= 4'd4;
    end else begin
      state_q  <= state_d;
      retry_q  <= retry_d;
      cnt_q    <= cnt_d;
      status_q <= status_d;
      l_head_q <= l_head_d;
      l_top_q  <= l_top_d;
      l_fill_q <= l_fill_d;
      g_head_q <= g_head_d;
      g_top_q  <= g_top_d;
      g_fill_q <= g_fill_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WAITER_OFFER_MIN: wom_q <= cfg_data_i[8:0];
          CFG_GLOBAL_LOW_MARK:  glm_q <= cfg_data_i;
          CFG_LOCAL_HIGH_MARK:  lhm_q <= cfg_data_i[8:0];
          CFG_GRAB_MAX:         gm_q  <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  logic [31:0] lc32, gc32;
  assign lc32 = 32'(cur_fill);
  assign gc32 = 32'(g_fill_q);

  assign busy_o         = (state_q != S_IDLE);
  assign done_o         = (state_q == S_RESP);
  assign status_o       = status_q;
  assign item_out_o     = out_q;
  assign local_count_o  = lc32[8:0];
  assign global_count_o = gc32[9:0];

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held longer than one cycle");
  a_fell_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> $past(done_o)) else $error("busy dropped without a result");
  a_local_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> (32'(cur_fill) <= 32'(LOCAL_DEPTH))) else $error("local fill overrun");
  a_global_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(g_fill_q) <= 32'(GLOBAL_DEPTH)) else $error("global fill overrun");
  a_overflow_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_OVERFLOW) |-> (func_q == FUNC_PUSH))
    else $error("overflow reported on a take");
endmodule

FILE: sim/two_level_work_deque_checker.sv
// result checker for the two-level work deque: follows accepted items and register
// writes, keeps its own copy of the deques and compares every done strobe; uses tlwd_pkg
`timescale 1ns / 1ps
module two_level_work_deque_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic        func_i,
  input  logic [1:0]  worker_i,
  input  logic [63:0] item_i,
  input  logic [2:0]  waiting_workers_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [9:0]  cfg_data_i,
  input  logic        done_i,
  input  logic [1:0]  status_i,
  input  logic [63:0] item_out_i,
  input  logic [8:0]  local_count_i,
  input  logic [9:0]  global_count_i,
  output int          err_count_o,
  output int          pending_o
);
  import tlwd_pkg::*;

  localparam int unsigned NW = WORKERS_DEF;
  localparam int unsigned LD = LOCAL_DEPTH_DEF;
  localparam int unsigned GD = GLOBAL_DEPTH_DEF;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] item;
    logic [8:0]  lcount;
    logic [9:0]  gcount;
  } deque_result_t;

  deque_result_t answers_q[$];

  logic [63:0] lmem [NW][LD];
  logic [63:0] gmem [GD];
  int unsigned lhead [NW];
  int unsigned ltop  [NW];
  int unsigned lfill [NW];
  int unsigned ghead, gtop, gfill;
  int unsigned wom, glm, lhm, grab;

  function automatic int unsigned wrap_up(int unsigned v, int unsigned d);
    return (v + 1 >= d) ? 0 : v + 1;
  endfunction

  function automatic int unsigned wrap_down(int unsigned v, int unsigned d);
    return (v == 0) ? d - 1 : v - 1;
  endfunction

  function automatic bit local_push(int unsigned w, logic [63:0] v);
    if (lfill[w] >= LD) return 1'b0;
    // empty deque: head follows top
    if (lfill[w] == 0) lhead[w] = ltop[w];
    else ltop[w] = wrap_up(ltop[w], LD);
    lmem[w][ltop[w]] = v;
    lfill[w]++;
    return 1'b1;
  endfunction

  function automatic void global_push(logic [63:0] v);
    if (gfill >= GD) return;
    if (gfill == 0) ghead = gtop;
    else gtop = wrap_up(gtop, GD);
    gmem[gtop] = v;
    gfill++;
  endfunction

  function automatic logic [63:0] local_pop_top(int unsigned w);
    logic [63:0] v;
    v = lmem[w][ltop[w]];
    ltop[w] = wrap_down(ltop[w], LD);
    lfill[w]--;
    return v;
  endfunction

  function automatic void offer_to_global(int unsigned w, int unsigned waiting);
    int unsigned lc, n;
    logic [63:0] v;
    lc = lfill[w];
    if (!((waiting > 0 && lc > wom) || (gfill < glm && lc > lhm))) return;
    n = lc / 2;
    if (n > GD - gfill) n = GD - gfill;
    // oldest items leave from the bottom
    for (int i = 0; i < n; i++) begin
      v = lmem[w][lhead[w]];
      lhead[w] = wrap_up(lhead[w], LD);
      lfill[w]--;
      global_push(v);
    end
  endfunction

  function automatic void grab_from_global(int unsigned w);
    logic [63:0] v;
    for (int i = 0; i < grab; i++) begin
      if (gfill == 0 || lfill[w] >= LD) break;
      v = gmem[gtop];
      gtop = wrap_down(gtop, GD);
      gfill--;
      void'(local_push(w, v));
    end
  endfunction

  function automatic deque_result_t predict_deque_op(logic fn, int unsigned w,
                                                     logic [63:0] v, int unsigned waiting);
    deque_result_t r;
    r.item = '0;
    if (fn == FUNC_PUSH) begin
      if (local_push(w, v)) begin
        r.status = ST_PUSHED;
      end else begin
        offer_to_global(w, waiting);
        r.status = local_push(w, v) ? ST_PUSHED : ST_OVERFLOW;
      end
    end else begin
      offer_to_global(w, waiting);
      if (lfill[w] == 0) grab_from_global(w);
      if (lfill[w] > 0) begin
        r.item   = local_pop_top(w);
        r.status = ST_DELIVERED;
      end else begin
        r.status = ST_NO_WORK;
      end
    end
    r.lcount = lfill[w][8:0];
    r.gcount = gfill[9:0];
    return r;
  endfunction

  assign pending_o = answers_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    deque_result_t exp_r;
    if (!rst_ni) begin
      for (int w = 0; w < NW; w++) begin
        lhead[w] = 0;
        ltop[w]  = 0;
        lfill[w] = 0;
      end
      ghead = 0;
      gtop  = 0;
      gfill = 0;
      wom   = 2;
      glm   = 128;
      lhm   = 128;
      grab  = 4;
      answers_q.delete();
      err_count_o <= 0;
    end else begin
      if (done_i) begin
        if (answers_q.size() == 0) begin
          err_count_o <= err_count_o + 1;
          if (err_count_o < 10)
            $display("%0t: unexpected result status=%0d item=%h", $realtime, status_i,
                     item_out_i);
        end else begin
          exp_r = answers_q.pop_front();
          if (status_i !== exp_r.status || item_out_i !== exp_r.item ||
              local_count_i !== exp_r.lcount || global_count_i !== exp_r.gcount) begin
            err_count_o <= err_count_o + 1;
            if (err_count_o < 10)
              $display("%0t: mismatch exp st=%0d item=%h lc=%0d gc=%0d got st=%0d item=%h lc=%0d gc=%0d",
                       $realtime, exp_r.status, exp_r.item, exp_r.lcount, exp_r.gcount,
                       status_i, item_out_i, local_count_i, global_count_i);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_WAITER_OFFER_MIN: wom  = cfg_data_i[8:0];
          CFG_GLOBAL_LOW_MARK:  glm  = cfg_data_i;
          CFG_LOCAL_HIGH_MARK:  lhm  = cfg_data_i[8:0];
          CFG_GRAB_MAX:         grab = cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i)
        answers_q.push_back(predict_deque_op(func_i, worker_i % NW, item_i,
                                             waiting_workers_i));
    end
  end
endmodule

FILE: sim/two_level_work_deque_tb.sv
// top of the two-level work deque testbench: clock, reset, directed and random
// items, register phases and the verdict; uses tlwd_pkg and the checker
`timescale 1ns / 1ps
module two_level_work_deque_tb;
  import tlwd_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic        clk_i, rst_ni;
  logic        start_i, busy_o;
  logic        func_i;
  logic [1:0]  worker_i;
  logic [63:0] item_i;
  logic [2:0]  waiting_workers_i;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [9:0]  cfg_data_i;
  logic        done_o;
  logic [1:0]  status_o;
  logic [63:0] item_out_o;
  logic [8:0]  local_count_o;
  logic [9:0]  global_count_o;
  int          err_count, pending;
  int          cycles = 0;

  two_level_work_deque uut (.*);

  two_level_work_deque_checker chk (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .func_i, .worker_i, .item_i,
    .waiting_workers_i, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .done_i(done_o),
    .status_i(status_o), .item_out_i(item_out_o), .local_count_i(local_count_o),
    .global_count_i(global_count_o), .err_count_o(err_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("two_level_work_deque_tb failed");
      $finish;
    end
  end

  task automatic send_item(logic fn, logic [1:0] w, logic [63:0] v, logic [2:0] waiting);
    int gap;
    func_i            <= fn;
    worker_i          <= w;
    item_i            <= v;
    waiting_workers_i <= waiting;
    start_i           <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // hold off until every item has answered
  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [9:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_regs(int wom, int glm, int lhm, int grab);
    write_reg(CFG_WAITER_OFFER_MIN, 10'(wom));
    write_reg(CFG_GLOBAL_LOW_MARK, 10'(glm));
    write_reg(CFG_LOCAL_HIGH_MARK, 10'(lhm));
    write_reg(CFG_GRAB_MAX, 10'(grab));
  endtask

  // random items with a hot worker so that deques fill and overflow
  task automatic run_mix(int count, int push_pct, int max_wait);
    logic [1:0] hot;
    logic [1:0] w;
    logic       fn;
    hot = 2'($urandom_range(0, 3));
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 49) == 0) hot = 2'($urandom_range(0, 3));
      w  = ($urandom_range(0, 99) < 70) ? hot : 2'($urandom_range(0, 3));
      fn = ($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_TAKE;
      send_item(fn, w, {$urandom, $urandom}, 3'($urandom_range(0, max_wait)));
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    start_i           = 1'b0;
    func_i            = FUNC_PUSH;
    worker_i          = '0;
    item_i            = '0;
    waiting_workers_i = '0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CFG_WAITER_OFFER_MIN;
    cfg_data_i        = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty takes, extreme values, offer on take, refill from global
    send_item(FUNC_TAKE, 2'd0, '0, 3'd0);
    send_item(FUNC_PUSH, 2'd0, 64'd0, 3'd0);
    send_item(FUNC_PUSH, 2'd1, '1, 3'd4);
    send_item(FUNC_TAKE, 2'd0, '1, 3'd0);
    send_item(FUNC_TAKE, 2'd1, '0, 3'd0);
    send_item(FUNC_TAKE, 2'd2, '0, 3'd4);
    for (int i = 0; i < 6; i++)
      send_item(FUNC_PUSH, 2'd3, 64'hA5A5_0000_0000_0000 | 64'(i), 3'd0);
    send_item(FUNC_TAKE, 2'd3, '0, 3'd4);
    send_item(FUNC_TAKE, 2'd2, '0, 3'd0);
    send_item(FUNC_TAKE, 2'd2, '0, 3'd3);
    send_item(FUNC_TAKE, 2'd2, '0, 3'd1);
    send_item(FUNC_TAKE, 2'd2, '0, 3'd2);
    wait_drained();

    // no offers at all: local deques overflow
    set_regs(256, 0, 256, 8);
    for (int i = 0; i < 258; i++) send_item(FUNC_PUSH, 2'd1, {$urandom, $urandom}, 3'd4);
    run_mix(100, 60, 4);
    wait_drained();

    // offers everywhere: the global deque fills
    set_regs(0, 512, 0, 1);
    run_mix(350, 80, 4);
    wait_drained();

    // nothing is grabbed back, widest mark values
    set_regs(0, 1023, 511, 0);
    run_mix(200, 50, 4);
    wait_drained();

    set_regs(2, 128, 128, 4);
    run_mix(250, 55, 4);
    wait_drained();

    for (int p = 0; p < 3; p++) begin
      set_regs($urandom_range(0, 511), $urandom_range(0, 1023), $urandom_range(0, 511),
               $urandom_range(0, 15));
      run_mix(180, $urandom_range(40, 85), 4);
      wait_drained();
    end

    // let any stray result arrive
    repeat (50) @(posedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("two_level_work_deque_tb passed");
    end else begin
      $display("two_level_work_deque_tb failed");
    end
    $finish;
  end
endmodule

FILE: files.f
rtl/core/tlwd_pkg.sv
rtl/core/two_level_work_deque.sv
sim/two_level_work_deque_checker.sv
sim/two_level_work_deque_tb.sv
